FILE: sv/rvd_pkg.sv
package rvd_pkg;

	localparam logic [6:0] MAJ_LUI    = 7'h37;
	localparam logic [6:0] MAJ_AUIPC  = 7'h17;
	localparam logic [6:0] MAJ_JAL    = 7'h6F;
	localparam logic [6:0] MAJ_JALR   = 7'h67;
	localparam logic [6:0] MAJ_BRANCH = 7'h63;
	localparam logic [6:0] MAJ_LOAD   = 7'h03;
	localparam logic [6:0] MAJ_STORE  = 7'h23;
	localparam logic [6:0] MAJ_OPIMM  = 7'h13;
	localparam logic [6:0] MAJ_OP     = 7'h33;

	localparam logic [6:0] F7_ZERO   = 7'h00;
	localparam logic [6:0] F7_SUBSRA = 7'h20;
	localparam logic [6:0] F7_MEXT   = 7'h01;

	localparam logic [31:0] UPPER_MASK = 32'hFFFF_F000;

	localparam logic [2:0] F3_ADD  = 3'd0;
	localparam logic [2:0] F3_SLL  = 3'd1;
	localparam logic [2:0] F3_SLT  = 3'd2;
	localparam logic [2:0] F3_SLTU = 3'd3;
	localparam logic [2:0] F3_XOR  = 3'd4;
	localparam logic [2:0] F3_SR   = 3'd5;
	localparam logic [2:0] F3_OR   = 3'd6;
	localparam logic [2:0] F3_AND  = 3'd7;

	localparam logic [2:0] F3_BYTE  = 3'd0;
	localparam logic [2:0] F3_HALF  = 3'd1;
	localparam logic [2:0] F3_WORD  = 3'd2;
	localparam logic [2:0] F3_BYTEU = 3'd4;
	localparam logic [2:0] F3_HALFU = 3'd5;

	localparam logic [2:0] F3_BEQ  = 3'd0;
	localparam logic [2:0] F3_BNE  = 3'd1;
	localparam logic [2:0] F3_BLT  = 3'd4;
	localparam logic [2:0] F3_BGE  = 3'd5;
	localparam logic [2:0] F3_BLTU = 3'd6;
	localparam logic [2:0] F3_BGEU = 3'd7;

	localparam logic [1:0] SIZE_BYTE = 2'd0;
	localparam logic [1:0] SIZE_HALF = 2'd1;
	localparam logic [1:0] SIZE_WORD = 2'd2;

	localparam logic [2:0] REGS_NONE   = 3'b000;
	localparam logic [2:0] REGS_RD     = 3'b001;
	localparam logic [2:0] REGS_RD_RS1 = 3'b011;
	localparam logic [2:0] REGS_RS1_2  = 3'b110;
	localparam logic [2:0] REGS_ALL    = 3'b111;

	localparam logic [4:0] CLS_NONE   = 5'b00000;
	localparam logic [4:0] CLS_IMM    = 5'b00001;
	localparam logic [4:0] CLS_LOAD   = 5'b00010;
	localparam logic [4:0] CLS_STORE  = 5'b00100;
	localparam logic [4:0] CLS_BRANCH = 5'b01000;
	localparam logic [4:0] CLS_JUMP   = 5'b10000;

	typedef enum logic [2:0] {
		UNIT_ALU = 3'd0,
		UNIT_MUL = 3'd1,
		UNIT_DIV = 3'd2,
		UNIT_MEM = 3'd3,
		UNIT_BR  = 3'd4
	} unit_t;

	typedef enum logic [5:0] {
		OP_NOP    = 6'd0,
		OP_ADD    = 6'd1,
		OP_SUB    = 6'd2,
		OP_SLL    = 6'd3,
		OP_SLT    = 6'd4,
		OP_SLTU   = 6'd5,
		OP_XOR    = 6'd6,
		OP_SRL    = 6'd7,
		OP_SRA    = 6'd8,
		OP_OR     = 6'd9,
		OP_AND    = 6'd10,
		OP_LUI    = 6'd11,
		OP_AUIPC  = 6'd12,
		OP_MUL    = 6'd13,
		OP_MULH   = 6'd14,
		OP_MULHSU = 6'd15,
		OP_MULHU  = 6'd16,
		OP_DIV    = 6'd17,
		OP_DIVU   = 6'd18,
		OP_REM    = 6'd19,
		OP_REMU   = 6'd20,
		OP_LB     = 6'd21,
		OP_LH     = 6'd22,
		OP_LW     = 6'd23,
		OP_LBU    = 6'd24,
		OP_LHU    = 6'd25,
		OP_SB     = 6'd26,
		OP_SH     = 6'd27,
		OP_SW     = 6'd28,
		OP_BEQ    = 6'd29,
		OP_BNE    = 6'd30,
		OP_BLT    = 6'd31,
		OP_BGE    = 6'd32,
		OP_BLTU   = 6'd33,
		OP_BGEU   = 6'd34,
		OP_JAL    = 6'd35,
		OP_JALR   = 6'd36
	} op_t;

endpackage

FILE: sv/rv32im_instruction_decoder.sv
// Throughput: one item per cycle; busy stays low as the receiver never stalls.
// Pipeline: input register, one level of decode logic, result register.
// Reset: arst_n asynchronously clears the valid bits of both stages;
// payload registers are not reset.
module rv32im_instruction_decoder
	import rvd_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [31:0]        instruction,
	input  logic [63:0]        pc,
	output logic               done,
	output logic [63:0]        uop_pc,
	output logic [5:0]         operation,
	output logic [2:0]         unit,
	output logic [4:0]         dest_reg,
	output logic [4:0]         src1_reg,
	output logic [4:0]         src2_reg,
	output logic [2:0]         reg_use_mask,
	output logic [4:0]         class_mask,
	output logic signed [31:0] immediate,
	output logic [1:0]         access_size,
	output logic               access_unsigned
);

	logic        vld_s1;
	logic [31:0] instr_s1;
	logic [63:0] pc_s1;

	logic        vld_s2;
	logic [63:0] pc_s2;
	op_t         op_s2;
	unit_t       unit_s2;
	logic [4:0]  rd_s2;
	logic [4:0]  rs1_s2;
	logic [4:0]  rs2_s2;
	logic [2:0]  regs_s2;
	logic [4:0]  cls_s2;
	logic [31:0] imm_s2;
	logic [1:0]  size_s2;
	logic        uns_s2;

	logic [6:0]  opc;
	logic [2:0]  f3;
	logic [6:0]  f7;
	logic [31:0] imm_i;
	logic [31:0] imm_s;
	logic [31:0] imm_b;
	logic [31:0] imm_j;

	op_t         op_d;
	unit_t       unit_d;
	logic [2:0]  regs_d;
	logic [4:0]  cls_d;
	logic [31:0] imm_d;
	logic [1:0]  size_d;
	logic        uns_d;

	unit_t       unit_f;
	logic [2:0]  regs_f;
	logic [4:0]  cls_f;
	logic [1:0]  size_f;
	logic        uns_f;

	assign busy = 1'b0;

	assign opc = instr_s1[6:0];
	assign f3  = instr_s1[14:12];
	assign f7  = instr_s1[31:25];

	assign imm_i = {{20{instr_s1[31]}}, instr_s1[31:20]};
	assign imm_s = {{20{instr_s1[31]}}, instr_s1[31:25], instr_s1[11:7]};
	assign imm_b = {{20{instr_s1[31]}}, instr_s1[7], instr_s1[30:25],
		instr_s1[11:8], 1'b0};
	assign imm_j = {{12{instr_s1[31]}}, instr_s1[19:12], instr_s1[20],
		instr_s1[30:21], 1'b0};

	always_comb begin
		op_d   = OP_NOP;
		unit_d = UNIT_ALU;
		regs_d = REGS_NONE;
		cls_d  = CLS_NONE;
		imm_d  = '0;
		size_d = SIZE_WORD;
		uns_d  = 1'b0;
		unique case (opc)
			MAJ_OPIMM: begin
				imm_d  = imm_i;
				regs_d = REGS_RD_RS1;
				cls_d  = CLS_IMM;
				unique case (f3)
					F3_ADD:  op_d = OP_ADD;
					F3_SLL:  op_d = (f7 == F7_ZERO) ? OP_SLL : OP_NOP;
					F3_SLT:  op_d = OP_SLT;
					F3_SLTU: op_d = OP_SLTU;
					F3_XOR:  op_d = OP_XOR;
					F3_SR:   op_d = (f7 == F7_ZERO) ? OP_SRL :
						(f7 == F7_SUBSRA) ? OP_SRA : OP_NOP;
					F3_OR:   op_d = OP_OR;
					default: op_d = OP_AND;
				endcase
			end
			MAJ_OP: begin
				regs_d = REGS_ALL;
				if (f7 == F7_MEXT) begin
					op_d   = op_t'(OP_MUL + {3'b000, f3});
					unit_d = f3[2] ? UNIT_DIV : UNIT_MUL;
				end else if (f7 == F7_ZERO) begin
					unique case (f3)
						F3_ADD:  op_d = OP_ADD;
						F3_SLL:  op_d = OP_SLL;
						F3_SLT:  op_d = OP_SLT;
						F3_SLTU: op_d = OP_SLTU;
						F3_XOR:  op_d = OP_XOR;
						F3_SR:   op_d = OP_SRL;
						F3_OR:   op_d = OP_OR;
						default: op_d = OP_AND;
					endcase
				end else if (f7 == F7_SUBSRA) begin
					op_d = (f3 == F3_ADD) ? OP_SUB : (f3 == F3_SR) ? OP_SRA : OP_NOP;
				end
			end
			MAJ_LOAD: begin
				imm_d  = imm_i;
				unit_d = UNIT_MEM;
				regs_d = REGS_RD_RS1;
				cls_d  = CLS_LOAD;
				unique case (f3)
					F3_BYTE: begin
						op_d   = OP_LB;
						size_d = SIZE_BYTE;
					end
					F3_HALF: begin
						op_d   = OP_LH;
						size_d = SIZE_HALF;
					end
					F3_WORD: op_d = OP_LW;
					F3_BYTEU: begin
						op_d   = OP_LBU;
						size_d = SIZE_BYTE;
						uns_d  = 1'b1;
					end
					F3_HALFU: begin
						op_d   = OP_LHU;
						size_d = SIZE_HALF;
						uns_d  = 1'b1;
					end
					default: op_d = OP_NOP;
				endcase
			end
			MAJ_STORE: begin
				imm_d  = imm_s;
				unit_d = UNIT_MEM;
				regs_d = REGS_RS1_2;
				cls_d  = CLS_STORE;
				unique case (f3)
					F3_BYTE: begin
						op_d   = OP_SB;
						size_d = SIZE_BYTE;
					end
					F3_HALF: begin
						op_d   = OP_SH;
						size_d = SIZE_HALF;
					end
					F3_WORD: op_d = OP_SW;
					default: op_d = OP_NOP;
				endcase
			end
			MAJ_BRANCH: begin
				imm_d  = imm_b;
				unit_d = UNIT_BR;
				regs_d = REGS_RS1_2;
				cls_d  = CLS_BRANCH;
				unique case (f3)
					F3_BEQ:  op_d = OP_BEQ;
					F3_BNE:  op_d = OP_BNE;
					F3_BLT:  op_d = OP_BLT;
					F3_BGE:  op_d = OP_BGE;
					F3_BLTU: op_d = OP_BLTU;
					F3_BGEU: op_d = OP_BGEU;
					default: op_d = OP_NOP;
				endcase
			end
			MAJ_JAL: begin
				op_d   = OP_JAL;
				unit_d = UNIT_BR;
				regs_d = REGS_RD;
				cls_d  = CLS_JUMP;
				imm_d  = imm_j;
			end
			MAJ_JALR: begin
				if (f3 == F3_ADD) begin
					op_d   = OP_JALR;
					unit_d = UNIT_BR;
					regs_d = REGS_RD_RS1;
					cls_d  = CLS_JUMP;
					imm_d  = imm_i;
				end
			end
			MAJ_LUI, MAJ_AUIPC: begin
				op_d   = (opc == MAJ_LUI) ? OP_LUI : OP_AUIPC;
				regs_d = REGS_RD;
				cls_d  = CLS_IMM;
				imm_d  = instr_s1 & UPPER_MASK;
			end
			default: begin
				op_d = OP_NOP;
			end
		endcase
	end

	// drop every flag on an illegal encoding; the immediate is kept; the rd use bit clears when rd is x0
	always_comb begin
		unit_f = unit_d;
		regs_f = regs_d;
		cls_f  = cls_d;
		size_f = size_d;
		uns_f  = uns_d;
		if (op_d == OP_NOP) begin
			unit_f = UNIT_ALU;
			regs_f = REGS_NONE;
			cls_f  = CLS_NONE;
			size_f = SIZE_WORD;
			uns_f  = 1'b0;
		end
		if (instr_s1[11:7] == 5'd0) begin
			regs_f[0] = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			vld_s1 <= start & ~busy;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			instr_s1 <= instruction;
			pc_s1    <= pc;
		end
		if (vld_s1) begin
			pc_s2   <= pc_s1;
			op_s2   <= op_d;
			unit_s2 <= unit_f;
			rd_s2   <= instr_s1[11:7];
			rs1_s2  <= instr_s1[19:15];
			rs2_s2  <= instr_s1[24:20];
			regs_s2 <= regs_f;
			cls_s2  <= cls_f;
			imm_s2  <= imm_d;
			size_s2 <= size_f;
			uns_s2  <= uns_f;
		end
	end

	assign done            = vld_s2;
	assign uop_pc          = pc_s2;
	assign operation       = op_s2;
	assign unit            = unit_s2;
	assign dest_reg        = rd_s2;
	assign src1_reg        = rs1_s2;
	assign src2_reg        = rs2_s2;
	assign reg_use_mask    = regs_s2;
	assign class_mask      = cls_s2;
	assign immediate       = imm_s2;
	assign access_size     = size_s2;
	assign access_unsigned = uns_s2;

endmodule

FILE: tb/rv32im_instruction_decoder_tb.sv
`timescale 1ns / 100ps

module rv32im_instruction_decoder_tb;
	import rvd_pkg::*;

	localparam logic [6:0] MAJ_FENCE  = 7'h0F;
	localparam logic [6:0] MAJ_SYSTEM = 7'h73;
	localparam int CYCLE_LIMIT = 400000;
	localparam int RANDOM_ITEMS = 2000;
	localparam logic [6:0] KNOWN_OPCODES [11] = '{MAJ_LUI, MAJ_AUIPC, MAJ_JAL, MAJ_JALR,
		MAJ_BRANCH, MAJ_LOAD, MAJ_STORE, MAJ_OPIMM, MAJ_OP, MAJ_FENCE, MAJ_SYSTEM};

	typedef struct {
		logic [63:0]        pc;
		op_t                op;
		unit_t              unit;
		logic [4:0]         rd;
		logic [4:0]         rs1;
		logic [4:0]         rs2;
		logic [2:0]         regs;
		logic [4:0]         cls;
		logic signed [31:0] imm;
		logic [1:0]         size;
		logic               uns;
	} uop_t;

	class uop_scoreboard;
		uop_t expected_uops[$];
		int mismatches = 0;
		int checked = 0;
		int nops = 0;

		function uop_t decode_uop(logic [31:0] w, logic [63:0] p);
			uop_t u;
			logic [6:0] opc;
			logic [6:0] f7;
			logic [2:0] f3;
			logic [31:0] imm_i;
			logic [31:0] imm_s;
			logic [31:0] imm_b;
			logic [31:0] imm_j;
			opc = w[6:0];
			f3 = w[14:12];
			f7 = w[31:25];
			imm_i = {{20{w[31]}}, w[31:20]};
			imm_s = {{20{w[31]}}, w[31:25], w[11:7]};
			imm_b = {{19{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
			imm_j = {{11{w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};
			u.pc = p;
			u.op = OP_NOP;
			u.unit = UNIT_ALU;
			u.rd = w[11:7];
			u.rs1 = w[19:15];
			u.rs2 = w[24:20];
			u.regs = REGS_NONE;
			u.cls = CLS_NONE;
			u.imm = '0;
			u.size = SIZE_WORD;
			u.uns = 1'b0;
			case (opc)
				MAJ_OPIMM: begin
					u.imm = imm_i;
					u.regs = REGS_RD_RS1;
					u.cls = CLS_IMM;
					case (f3)
						F3_ADD:  u.op = OP_ADD;
						F3_SLL:  u.op = (f7 == F7_ZERO) ? OP_SLL : OP_NOP;
						F3_SLT:  u.op = OP_SLT;
						F3_SLTU: u.op = OP_SLTU;
						F3_XOR:  u.op = OP_XOR;
						F3_SR:   u.op = (f7 == F7_ZERO) ? OP_SRL :
							(f7 == F7_SUBSRA) ? OP_SRA : OP_NOP;
						F3_OR:   u.op = OP_OR;
						default: u.op = OP_AND;
					endcase
				end
				MAJ_OP: begin
					u.regs = REGS_ALL;
					if (f7 == F7_MEXT) begin
						u.op = op_t'(OP_MUL + f3);
						u.unit = (f3 < 3'd4) ? UNIT_MUL : UNIT_DIV;
					end else if (f7 == F7_ZERO) begin
						case (f3)
							F3_ADD:  u.op = OP_ADD;
							F3_SLL:  u.op = OP_SLL;
							F3_SLT:  u.op = OP_SLT;
							F3_SLTU: u.op = OP_SLTU;
							F3_XOR:  u.op = OP_XOR;
							F3_SR:   u.op = OP_SRL;
							F3_OR:   u.op = OP_OR;
							default: u.op = OP_AND;
						endcase
					end else if (f7 == F7_SUBSRA) begin
						u.op = (f3 == F3_ADD) ? OP_SUB : (f3 == F3_SR) ? OP_SRA : OP_NOP;
					end
				end
				MAJ_LOAD: begin
					u.imm = imm_i;
					u.unit = UNIT_MEM;
					u.regs = REGS_RD_RS1;
					u.cls = CLS_LOAD;
					case (f3)
						F3_BYTE: begin
							u.op = OP_LB;
							u.size = SIZE_BYTE;
						end
						F3_HALF: begin
							u.op = OP_LH;
							u.size = SIZE_HALF;
						end
						F3_WORD: u.op = OP_LW;
						F3_BYTEU: begin
							u.op = OP_LBU;
							u.size = SIZE_BYTE;
							u.uns = 1'b1;
						end
						F3_HALFU: begin
							u.op = OP_LHU;
							u.size = SIZE_HALF;
							u.uns = 1'b1;
						end
						default: u.op = OP_NOP;
					endcase
				end
				MAJ_STORE: begin
					u.imm = imm_s;
					u.unit = UNIT_MEM;
					u.regs = REGS_RS1_2;
					u.cls = CLS_STORE;
					case (f3)
						F3_BYTE: begin
							u.op = OP_SB;
							u.size = SIZE_BYTE;
						end
						F3_HALF: begin
							u.op = OP_SH;
							u.size = SIZE_HALF;
						end
						F3_WORD: u.op = OP_SW;
						default: u.op = OP_NOP;
					endcase
				end
				MAJ_BRANCH: begin
					u.imm = imm_b;
					u.unit = UNIT_BR;
					u.regs = REGS_RS1_2;
					u.cls = CLS_BRANCH;
					case (f3)
						F3_BEQ:  u.op = OP_BEQ;
						F3_BNE:  u.op = OP_BNE;
						F3_BLT:  u.op = OP_BLT;
						F3_BGE:  u.op = OP_BGE;
						F3_BLTU: u.op = OP_BLTU;
						F3_BGEU: u.op = OP_BGEU;
						default: u.op = OP_NOP;
					endcase
				end
				MAJ_JAL: begin
					u.op = OP_JAL;
					u.unit = UNIT_BR;
					u.regs = REGS_RD;
					u.cls = CLS_JUMP;
					u.imm = imm_j;
				end
				MAJ_JALR: begin
					if (f3 == '0) begin
						u.op = OP_JALR;
						u.unit = UNIT_BR;
						u.regs = REGS_RD_RS1;
						u.cls = CLS_JUMP;
						u.imm = imm_i;
					end
				end
				MAJ_LUI, MAJ_AUIPC: begin
					u.op = (opc == MAJ_LUI) ? OP_LUI : OP_AUIPC;
					u.regs = REGS_RD;
					u.cls = CLS_IMM;
					u.imm = w & UPPER_MASK;
				end
				default: ;
			endcase
			// illegal encodings keep the format immediate but drop every flag
			if (u.op == OP_NOP) begin
				u.unit = UNIT_ALU;
				u.regs = REGS_NONE;
				u.cls = CLS_NONE;
				u.size = SIZE_WORD;
				u.uns = 1'b0;
			end
			if (u.rd == '0)
				u.regs[0] = 1'b0;
			return u;
		endfunction

		function void note_item(logic [31:0] w, logic [63:0] p);
			uop_t u;
			u = decode_uop(w, p);
			if (u.op == OP_NOP)
				nops++;
			expected_uops.push_back(u);
		endfunction

		function void compare_field(logic [63:0] item_pc, string name,
				logic [63:0] want, logic [63:0] got);
			if (want !== got) begin
				mismatches++;
				if (mismatches <= 10)
					$display("pc %h: %s expected %h got %h", item_pc, name, want, got);
			end
		endfunction

		function void check_result(uop_t got);
			uop_t want;
			checked++;
			if (expected_uops.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("stray result: pc %h operation %0d", got.pc, got.op);
				return;
			end
			want = expected_uops.pop_front();
			compare_field(want.pc, "uop_pc", want.pc, got.pc);
			compare_field(want.pc, "operation", want.op, got.op);
			compare_field(want.pc, "unit", want.unit, got.unit);
			compare_field(want.pc, "dest_reg", want.rd, got.rd);
			compare_field(want.pc, "src1_reg", want.rs1, got.rs1);
			compare_field(want.pc, "src2_reg", want.rs2, got.rs2);
			compare_field(want.pc, "reg_use_mask", want.regs, got.regs);
			compare_field(want.pc, "class_mask", want.cls, got.cls);
			compare_field(want.pc, "immediate", want.imm, got.imm);
			compare_field(want.pc, "access_size", want.size, got.size);
			compare_field(want.pc, "access_unsigned", want.uns, got.uns);
		endfunction
	endclass

	logic               clk;
	logic               arst_n = 1'b0;
	logic               start = 1'b0;
	logic               busy;
	logic [31:0]        instruction = '0;
	logic [63:0]        pc = '0;
	logic               done;
	logic [63:0]        uop_pc;
	logic [5:0]         operation;
	logic [2:0]         unit;
	logic [4:0]         dest_reg;
	logic [4:0]         src1_reg;
	logic [4:0]         src2_reg;
	logic [2:0]         reg_use_mask;
	logic [4:0]         class_mask;
	logic signed [31:0] immediate;
	logic [1:0]         access_size;
	logic               access_unsigned;

	uop_scoreboard sb = new();
	int cycles = 0;
	int items_sent = 0;

	rv32im_instruction_decoder dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.start           (start),
		.busy            (busy),
		.instruction     (instruction),
		.pc              (pc),
		.done            (done),
		.uop_pc          (uop_pc),
		.operation       (operation),
		.unit            (unit),
		.dest_reg        (dest_reg),
		.src1_reg        (src1_reg),
		.src2_reg        (src2_reg),
		.reg_use_mask    (reg_use_mask),
		.class_mask      (class_mask),
		.immediate       (immediate),
		.access_size     (access_size),
		.access_unsigned (access_unsigned)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("rv32im_instruction_decoder_tb: errors");
			$finish;
		end
	end

	always @(posedge clk) begin
		uop_t seen;
		if (arst_n) begin
			if (start && !busy)
				sb.note_item(instruction, pc);
			if (done) begin
				seen = '{uop_pc, op_t'(operation), unit_t'(unit), dest_reg, src1_reg,
					src2_reg, reg_use_mask, class_mask, immediate, access_size,
					access_unsigned};
				sb.check_result(seen);
			end
		end
	end

	function automatic logic [31:0] enc(logic [6:0] opc, logic [2:0] f3, logic [6:0] f7,
			logic [4:0] rd, logic [4:0] rs1, logic [4:0] rs2);
		return {f7, rs2, rs1, f3, rd, opc};
	endfunction

	function automatic logic [31:0] random_word();
		logic [31:0] w;
		logic [6:0] f7;
		logic [4:0] rd;
		w = $urandom;
		if ($urandom_range(0, 9) == 0)
			return w;
		case ($urandom_range(0, 9))
			0, 1, 2, 3: f7 = F7_ZERO;
			4, 5:       f7 = F7_SUBSRA;
			6, 7:       f7 = F7_MEXT;
			default:    f7 = w[31:25];
		endcase
		rd = ($urandom_range(0, 7) == 0) ? 5'd0 : w[11:7];
		return {f7, w[24:12], rd, KNOWN_OPCODES[$urandom_range(0, 10)]};
	endfunction

	function automatic int idle_gap(int n);
		int r;
		if ((n % 300) < 50)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 45)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	task automatic send_item(input logic [31:0] w, input logic [63:0] p, input int gap);
		start <= 1'b1;
		instruction <= w;
		pc <= p;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		items_sent++;
		@(negedge clk);
		if (gap > 0) begin
			start <= 1'b0;
			instruction <= $urandom;
			pc <= {$urandom, $urandom};
			repeat (gap) @(negedge clk);
		end
	endtask

	task automatic drain();
		while (sb.expected_uops.size() != 0)
			@(negedge clk);
	endtask

	initial begin
		logic [31:0] words[$];
		logic [63:0] p;
		int directed_n;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		words = '{
			32'h0000_0000,
			32'hFFFF_FFFF,
			enc(MAJ_FENCE, 3'd0, 7'h00, 5'd0, 5'd0, 5'd0),
			enc(MAJ_SYSTEM, 3'd0, 7'h00, 5'd0, 5'd0, 5'd0),
			enc(MAJ_OPIMM, F3_ADD, 7'h40, 5'd0, 5'd31, 5'd0),
			enc(MAJ_OPIMM, F3_ADD, 7'h3F, 5'd31, 5'd0, 5'd31),
			enc(MAJ_OPIMM, F3_SLL, F7_SUBSRA, 5'd5, 5'd6, 5'd7),
			enc(MAJ_OPIMM, F3_SR, F7_SUBSRA, 5'd8, 5'd9, 5'd31),
			enc(MAJ_OPIMM, F3_SR, F7_MEXT, 5'd8, 5'd9, 5'd3),
			enc(MAJ_OP, F3_ADD, F7_SUBSRA, 5'd31, 5'd31, 5'd31),
			enc(MAJ_OP, F3_XOR, F7_SUBSRA, 5'd1, 5'd2, 5'd3),
			enc(MAJ_OP, F3_ADD, 7'h7F, 5'd1, 5'd2, 5'd3),
			enc(MAJ_OP, 3'd0, F7_MEXT, 5'd10, 5'd11, 5'd12),
			enc(MAJ_OP, 3'd3, F7_MEXT, 5'd0, 5'd11, 5'd12),
			enc(MAJ_OP, 3'd4, F7_MEXT, 5'd10, 5'd0, 5'd0),
			enc(MAJ_OP, 3'd7, F7_MEXT, 5'd31, 5'd31, 5'd31),
			enc(MAJ_LOAD, F3_BYTEU, 7'h7F, 5'd3, 5'd4, 5'd31),
			enc(MAJ_LOAD, F3_HALFU, 7'h00, 5'd3, 5'd4, 5'd1),
			enc(MAJ_LOAD, 3'd3, 7'h55, 5'd3, 5'd4, 5'd1),
			enc(MAJ_STORE, 3'd3, 7'h2A, 5'd31, 5'd4, 5'd5),
			enc(MAJ_STORE, F3_WORD, 7'h7F, 5'd31, 5'd4, 5'd5),
			enc(MAJ_BRANCH, 3'd2, 7'h7F, 5'd31, 5'd1, 5'd2),
			enc(MAJ_BRANCH, F3_BGEU, 7'h40, 5'd1, 5'd1, 5'd2),
			enc(MAJ_JAL, 3'd0, 7'h40, 5'd0, 5'd0, 5'd0),
			enc(MAJ_JALR, 3'd1, 7'h7F, 5'd1, 5'd2, 5'd31),
			enc(MAJ_JALR, 3'd0, 7'h7F, 5'd1, 5'd2, 5'd31),
			enc(MAJ_LUI, 3'd7, 7'h7F, 5'd0, 5'd31, 5'd31),
			enc(MAJ_AUIPC, 3'd5, 7'h40, 5'd17, 5'd0, 5'd0)
		};
		directed_n = words.size();
		foreach (words[i]) begin
			case (i % 3)
				0:       p = '0;
				1:       p = '1;
				default: p = {$urandom, $urandom};
			endcase
			send_item(words[i], p, (i % 4 == 3) ? 2 : 0);
		end

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			send_item(random_word(), {$urandom, $urandom}, idle_gap(n));
			// hold off the sender until the pipeline is empty
			if (n == RANDOM_ITEMS / 2) begin
				send_item(random_word(), {$urandom, $urandom}, 1);
				drain();
			end
		end
		send_item(random_word(), {$urandom, $urandom}, 1);
		drain();
		repeat (8) @(negedge clk);

		$display("sent %0d instruction words (%0d directed), checked %0d micro-ops, %0d no-ops",
			items_sent, directed_n, sb.checked, sb.nops);
		$display("%0d field mismatches, %0d micro-ops still outstanding",
			sb.mismatches, sb.expected_uops.size());
		if (sb.mismatches == 0 && sb.expected_uops.size() == 0) begin
			$display("rv32im_instruction_decoder_tb: clean");
		end else begin
			$display("rv32im_instruction_decoder_tb: errors");
		end
		$finish;
	end

endmodule
